FILE: rtl/itora_pkg.sv
package itora_pkg;

   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

   localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_MINUS  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_ERROR   = 8'h00;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SIGN,
      ST_READ,
      ST_EMIT,
      ST_BAD
   } state_type;

   typedef struct packed {
      logic               start;
      logic [RADIX_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic               done;
      logic [RADIX_W-1:0] remainder;
   } div_stat_type;

   // digit value 0..35 to lower-case ascii
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] digit);
      logic [CHAR_W-1:0] wide;
      wide = {{(CHAR_W-RADIX_W){1'b0}}, digit};
      if (digit < DEC_DIGITS) begin
         digit_char = ASCII_ZERO + wide;
      end else begin
         digit_char = ASCII_LOWER_A + wide - {{(CHAR_W-RADIX_W){1'b0}}, DEC_DIGITS};
      end
   endfunction

endpackage

FILE: rtl/itora_if.sv
interface itora_req_if #(parameter int VALUE_WIDTH = 32);
   import itora_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [RADIX_W-1:0]            radix;

   modport source (output valid, value, radix, input ready);
   modport sink   (input valid, value, radix, output ready);
endinterface

interface itora_rsp_if;
   import itora_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              last;
   logic              bad_radix;

   modport source (output valid, character, last, bad_radix, input ready);
   modport sink   (input valid, character, last, bad_radix, output ready);
endinterface

FILE: rtl/itora_div.sv
module itora_div
   import itora_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  div_cmd_type            cmd,
   input  logic [VALUE_WIDTH-1:0] dividend,
   output div_stat_type           stat,
   output logic [VALUE_WIDTH-1:0] quotient
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     divisor_ff, divisor_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [RADIX_W:0]       trial;
   logic                   fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (cmd.start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = cmd.divisor;
         cnt_in     = CNT_W'(VALUE_WIDTH);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], fits};
         rem_in = fits ? RADIX_W'(trial - {1'b0, divisor_ff}) : RADIX_W'(trial);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient       = quo_ff;
   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;

endmodule

FILE: rtl/itora_digit_buf.sv
module itora_digit_buf
   import itora_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [RADIX_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [RADIX_W-1:0] rd_data
);

   logic [RADIX_W-1:0] mem [DEPTH];
   logic [RADIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/integer_to_radix_ascii_top.sv
// one word in, one word out per character; digits are produced lsd first by a
// shared bit-serial divider, then read back msd first
// one item at a time: req ready only while idle; bad radix answers in the cycle after accept
// synchronous active-high reset returns the sequencer and divider to idle
module integer_to_radix_ascii_top
   import itora_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   itora_req_if.sink   req_ch,
   itora_rsp_if.source rsp_ch
);

   localparam int ADDR_W = $clog2(VALUE_WIDTH);
   localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]     radix_ff, radix_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       ndig_ff, ndig_in;
   logic [ADDR_W-1:0]      idx_ff, idx_in;

   logic                   req_fire, rsp_fire, bad_radix;
   div_cmd_type            div_cmd;
   div_stat_type           div_stat;
   logic [VALUE_WIDTH-1:0] quotient;
   logic                   wr_en, rd_en;
   logic [RADIX_W-1:0]     rd_digit;

   assign req_fire  = req_ch.valid & req_ch.ready;
   assign rsp_fire  = rsp_ch.valid & rsp_ch.ready;
   assign bad_radix = (req_ch.radix < RADIX_MIN) || (req_ch.radix > RADIX_MAX);

   itora_div #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (mag_ff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   itora_digit_buf #(
      .DEPTH  (VALUE_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ndig_ff[ADDR_W-1:0]),
      .wr_data (div_stat.remainder),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_digit)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = bad_radix ? ST_BAD : ST_DIV_START;
            end
         end
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               if (quotient != '0) begin
                  state_in = ST_DIV_START;
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN: begin
            if (rsp_fire) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_fire) begin
               state_in = (idx_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         ST_BAD: begin
            if (rsp_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready      = 1'b0;
      rsp_ch.valid      = 1'b0;
      rsp_ch.character  = CHAR_ERROR;
      rsp_ch.last       = 1'b0;
      rsp_ch.bad_radix  = 1'b0;
      div_cmd.start     = 1'b0;
      div_cmd.divisor   = radix_ff;
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      case (state_ff)
         ST_IDLE:      req_ch.ready  = 1'b1;
         ST_DIV_START: div_cmd.start = 1'b1;
         ST_DIV_WAIT:  wr_en         = div_stat.done;
         ST_SIGN: begin
            rsp_ch.valid     = 1'b1;
            rsp_ch.character = ASCII_MINUS;
         end
         ST_READ:      rd_en         = 1'b1;
         ST_EMIT: begin
            rsp_ch.valid     = 1'b1;
            rsp_ch.character = digit_char(rd_digit);
            rsp_ch.last      = (idx_ff == '0);
         end
         ST_BAD: begin
            rsp_ch.valid     = 1'b1;
            rsp_ch.character = CHAR_ERROR;
            rsp_ch.last      = 1'b1;
            rsp_ch.bad_radix = 1'b1;
         end
         default: req_ch.ready = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      mag_in   = mag_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      ndig_in  = ndig_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in   = req_ch.value[VALUE_WIDTH-1];
               // most negative value wraps to its unsigned magnitude
               mag_in   = req_ch.value[VALUE_WIDTH-1] ? (~req_ch.value + 1'b1) : req_ch.value;
               radix_in = req_ch.radix;
               ndig_in  = '0;
            end
         end
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               mag_in  = quotient;
               ndig_in = ndig_ff + CNT_W'(1);
               idx_in  = ndig_ff[ADDR_W-1:0];
            end
         end
         ST_EMIT: begin
            if (rsp_fire && idx_ff != '0) begin
               idx_in = idx_ff - ADDR_W'(1);
            end
         end
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      ndig_ff  <= ndig_in;
      idx_ff   <= idx_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
